[design/pdm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared types, widths, register indexes and command codes of the PWM
// period and duty monitor.
// ----------------------------------------------------------------------------
package pdm_pkg;

    localparam int TICK_W   = 32;
    localparam int TOTAL_W  = TICK_W + 1;
    localparam int PAIR_W   = 31;
    localparam int NOW_W    = 48;
    localparam int FREQ_W   = 32;
    localparam int DUTY_W   = 8;
    localparam int TIMEOUT_W = 32;

    localparam int TIME_WIDTH_DEF = 48;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNSTABLE_FREQ = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNSTABLE_DUTY = 2'd3;

    localparam logic [FREQ_W-1:0]    CLOCK_HZ_RST      = 32'd125000000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_US_RST    = 32'd1000000;
    localparam logic [FREQ_W-1:0]    UNSTABLE_FREQ_RST = 32'hFFFF_FFFF;
    localparam logic [DUTY_W-1:0]    UNSTABLE_DUTY_RST = 8'd255;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd100;
    localparam logic [DUTY_W-1:0] DUTY_NONE = 8'd0;

    // Command codes passed from the front end to the back end.
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_HOLD     = 2'd0;
    localparam logic [OP_W-1:0] OP_DECODE   = 2'd1;
    localparam logic [OP_W-1:0] OP_UNSTABLE = 2'd2;
    localparam logic [OP_W-1:0] OP_TIMEOUT  = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [FREQ_W-1:0]    clock_hz;
        logic [TIMEOUT_W-1:0] timeout_us;
        logic [FREQ_W-1:0]    unstable_freq;
        logic [DUTY_W-1:0]    unstable_duty;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TICK_W-1:0]  high;
        logic [TOTAL_W-1:0] total;
        logic               pin;
    } t_cmd;

endpackage

[design/pdm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdm_front
// Accepts refresh transactions, tracks the pair count and the time of the
// last pair, and turns each refresh into one command for the back end.
// ----------------------------------------------------------------------------
module pdm_front
    import pdm_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [TICK_W-1:0] i_high_ticks,
    input  logic [TICK_W-1:0] i_low_ticks,
    input  logic [PAIR_W-1:0] i_pair_count,
    input  logic              i_capture_done,
    input  logic [NOW_W-1:0]  i_now_us,
    input  logic              i_pin_level,
    input  t_cfg              i_cfg,
    output t_cmd              o_cmd
);

    logic [PAIR_W-1:0]     r_seen_pairs;
    logic [TIME_WIDTH-1:0] r_last_time;

    logic [63:0]           now_ext;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] last_eff;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  new_pair;
    logic                  timed_out;
    logic [TOTAL_W-1:0]    total;

    assign now_ext  = 64'(i_now_us);
    assign now_t    = now_ext[TIME_WIDTH-1:0];
    assign new_pair = (i_pair_count != r_seen_pairs);
    assign last_eff = new_pair ? now_t : r_last_time;
    assign elapsed  = now_t - last_eff;
    assign timed_out = !i_capture_done && (elapsed >= TIME_WIDTH'(i_cfg.timeout_us));
    assign total    = TOTAL_W'(i_high_ticks) + TOTAL_W'(i_low_ticks);

    // The timeout check comes before any decode, so it wins over a new pair.
    always_comb begin
        o_cmd.high  = i_high_ticks;
        o_cmd.total = total;
        o_cmd.pin   = i_pin_level;
        priority if (timed_out) begin
            o_cmd.op = OP_TIMEOUT;
        end else if (new_pair && (total == '0)) begin
            o_cmd.op = OP_UNSTABLE;
        end else if (new_pair) begin
            o_cmd.op = OP_DECODE;
        end else begin
            o_cmd.op = OP_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_pairs <= '0;
            r_last_time  <= '0;
        end else if (i_accept && new_pair) begin
            r_seen_pairs <= i_pair_count;
            r_last_time  <= now_t;
        end
    end

endmodule

[design/pdm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdm_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pdm_queue
    import pdm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/pdm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdm_back
// Executes commands: decodes frequency and duty with a shared restoring
// divider, applies the sentinel and static-level cases, and publishes the
// held values through an output register.
// ----------------------------------------------------------------------------
module pdm_back
    import pdm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_q_empty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [FREQ_W-1:0] o_freq_hz,
    output logic [DUTY_W-1:0] o_duty_pct,
    output logic              o_valid_res
);

    localparam int REM_W   = TOTAL_W + 2;
    localparam int NUM_W   = TOTAL_W + 1;
    localparam int PROD_W  = TICK_W + 7;
    localparam int DQ_W    = 7;
    localparam int CNT_W   = $clog2(FREQ_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FREQ = 2'd1;
    localparam logic [1:0] ST_DUTY = 2'd2;
    localparam logic [1:0] ST_PUB  = 2'd3;

    logic [1:0]         r_state;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_den;
    logic [FREQ_W-1:0]  r_sh;
    logic [CNT_W-1:0]   r_cnt;
    logic [FREQ_W-1:0]  r_freq;
    logic [PROD_W-1:0]  r_prod;
    logic [TOTAL_W-1:0] r_total;

    logic [FREQ_W-1:0]  r_held_freq;
    logic [DUTY_W-1:0]  r_held_duty;
    logic               r_held_valid;

    logic               r_out_valid;
    logic [FREQ_W-1:0]  r_out_freq;
    logic [DUTY_W-1:0]  r_out_duty;
    logic               r_out_vres;

    logic [NUM_W-1:0]   freq_num;
    logic [PROD_W-1:0]  duty_num;
    logic [REM_W-1:0]   trial;
    logic               ge;
    logic [DUTY_W-1:0]  duty_q;
    logic               out_load;

    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign freq_num = NUM_W'(i_cfg.clock_hz) + NUM_W'(i_cmd.total);
    assign duty_num = r_prod + PROD_W'(r_total >> 1);

    // One restoring step: the quotient bits shift into the low end of r_sh.
    assign trial = {r_rem[REM_W-2:0], r_sh[FREQ_W-1]};
    assign ge    = (trial >= r_den);

    assign duty_q   = DUTY_W'(r_sh[DQ_W-1:0]);
    assign out_load = (r_state == ST_PUB) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_held_freq  <= '0;
            r_held_duty  <= '0;
            r_held_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        unique case (i_cmd.op)
                            OP_DECODE: begin
                                r_state <= ST_FREQ;
                            end
                            OP_UNSTABLE: begin
                                r_held_freq  <= i_cfg.unstable_freq;
                                r_held_duty  <= i_cfg.unstable_duty;
                                r_held_valid <= 1'b0;
                                r_state      <= ST_PUB;
                            end
                            OP_TIMEOUT: begin
                                r_held_freq  <= '0;
                                r_held_duty  <= i_cmd.pin ? DUTY_FULL : DUTY_NONE;
                                r_held_valid <= 1'b1;
                                r_state      <= ST_PUB;
                            end
                            OP_HOLD: begin
                                r_state <= ST_PUB;
                            end
                        endcase
                    end
                end
                ST_FREQ: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_DUTY;
                    end
                end
                ST_DUTY: begin
                    if (r_cnt == '0) begin
                        r_held_freq  <= r_freq;
                        r_held_duty  <= (duty_q > DUTY_FULL) ? DUTY_FULL : duty_q;
                        r_held_valid <= 1'b1;
                        r_state      <= ST_PUB;
                    end
                end
                ST_PUB: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Divider datapath. The frequency quotient fits in 32 bits and the duty
    // quotient in 7 bits, so the upper numerator bits preload the remainder.
    always_ff @(posedge i_clk) begin
        priority if (o_pop) begin
            r_rem   <= REM_W'(freq_num[NUM_W-1:FREQ_W]);
            r_sh    <= freq_num[FREQ_W-1:0];
            r_den   <= REM_W'({i_cmd.total, 1'b0});
            r_cnt   <= CNT_W'(FREQ_W);
            r_prod  <= PROD_W'(i_cmd.high) * PROD_W'(DUTY_FULL);
            r_total <= i_cmd.total;
        end else if ((r_state == ST_FREQ) && (r_cnt == '0)) begin
            r_freq <= r_sh;
            r_rem  <= REM_W'(duty_num[PROD_W-1:DQ_W]);
            r_sh   <= {duty_num[DQ_W-1:0], (FREQ_W - DQ_W)'(0)};
            r_den  <= REM_W'(r_total);
            r_cnt  <= CNT_W'(DQ_W);
        end else if (((r_state == ST_FREQ) || (r_state == ST_DUTY)) && (r_cnt != '0)) begin
            r_rem <= ge ? (trial - r_den) : trial;
            r_sh  <= {r_sh[FREQ_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_freq <= r_held_freq;
            r_out_duty <= r_held_duty;
            r_out_vres <= r_held_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_freq_hz   = r_out_freq;
    assign o_duty_pct  = r_out_duty;
    assign o_valid_res = r_out_vres;

endmodule

[design/pwm_period_duty_monitor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_period_duty_monitor_unit
// PWM frequency and duty monitor: decodes capture loop counts into a
// frequency in hertz and a duty in percent, with timeout and sentinels.
// ----------------------------------------------------------------------------
// Every refresh transaction yields exactly one result transaction carrying
// the currently published frequency, duty and valid flag. A refresh whose
// pair count has changed and whose counts are nonzero is decoded by a
// shared restoring divider: 32 steps for the frequency and 7 for the duty,
// and the back end takes no new command until the result is published;
// all other refreshes go straight to publishing, and a stalled result
// holds the back end until it is taken. A two-entry command queue lets the
// front end take refreshes while a decode is still running. Configuration
// writes are always ready and must only be issued while the block is idle.
module pwm_period_duty_monitor_unit
    import pdm_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [TICK_W-1:0]    i_high_ticks,
    input  logic [TICK_W-1:0]    i_low_ticks,
    input  logic [PAIR_W-1:0]    i_pair_count,
    input  logic                 i_capture_done,
    input  logic [NOW_W-1:0]     i_now_us,
    input  logic                 i_pin_level,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [FREQ_W-1:0]    o_freq_hz,
    output logic [DUTY_W-1:0]    o_duty_pct,
    output logic                 o_valid_res,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FREQ_W-1:0]    i_cfg_data
);

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic in_accept;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_hz      <= CLOCK_HZ_RST;
            r_cfg.timeout_us    <= TIMEOUT_US_RST;
            r_cfg.unstable_freq <= UNSTABLE_FREQ_RST;
            r_cfg.unstable_duty <= UNSTABLE_DUTY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CLOCK_HZ:      r_cfg.clock_hz      <= i_cfg_data;
                REG_TIMEOUT_US:    r_cfg.timeout_us    <= TIMEOUT_W'(i_cfg_data);
                REG_UNSTABLE_FREQ: r_cfg.unstable_freq <= i_cfg_data;
                REG_UNSTABLE_DUTY: r_cfg.unstable_duty <= i_cfg_data[DUTY_W-1:0];
            endcase
        end
    end

    pdm_front #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_high_ticks   (i_high_ticks),
        .i_low_ticks    (i_low_ticks),
        .i_pair_count   (i_pair_count),
        .i_capture_done (i_capture_done),
        .i_now_us       (i_now_us),
        .i_pin_level    (i_pin_level),
        .i_cfg          (r_cfg),
        .o_cmd          (front_cmd)
    );

    pdm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (queue_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_cmd       (queue_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_freq_hz   (o_freq_hz),
        .o_duty_pct  (o_duty_pct),
        .o_valid_res (o_valid_res)
    );

endmodule
